@@ src/ght_pkg.sv @@
`timescale 1ns / 1ps
package ght_pkg;

  localparam int GEN_W   = 16;
  localparam int IDX_W   = 16;
  localparam int WORD_W  = 32;
  localparam int TDATA_W = 72;

  localparam logic [GEN_W-1:0] GEN_MAX   = 16'hffff;
  localparam logic [GEN_W-1:0] GEN_FIRST = 16'd1;
  localparam logic [GEN_W-1:0] GEN_RESET = 16'd1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_t;

  // classified request
  typedef struct packed {
    op_t               op;
    logic              ok;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  gen;
    logic [WORD_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

@@ src/ght_ram.sv @@
`timescale 1ns / 1ps
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ght_front.sv @@
`timescale 1ns / 1ps
module ght_front #(
  parameter int NUM_SLOTS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [ght_pkg::TDATA_W-1:0] in_tdata,
  input  logic                     pop,
  output ght_pkg::q_head_t         head
);
  import ght_pkg::*;

  logic [IDX_W-1:0]  enc;
  logic [GEN_W-1:0]  gen;
  logic              ok;
  cmd_t              cmd;
  logic              push;

  cmd_t              q_r [2];
  logic              wp_r;
  logic              rp_r;
  logic [1:0]        cnt_r;

  // handle decode and range check
  always_comb begin
    enc = in_tdata[17:2];
    gen = in_tdata[33:18];
    ok  = (enc != '0) && (gen != '0) && (enc <= IDX_W'(NUM_SLOTS));
    cmd.op      = op_t'(in_tdata[1:0]);
    cmd.ok      = ok;
    cmd.idx     = ok ? (enc - IDX_W'(1)) : '0;
    cmd.gen     = gen;
    cmd.payload = in_tdata[65:34];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = q_r[rp_r];

endmodule

@@ src/ght_back.sv @@
`timescale 1ns / 1ps
module ght_back #(
  parameter int NUM_SLOTS    = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ght_pkg::q_head_t            head,
  output logic                        pop,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output ght_pkg::status_t            out_status,
  output logic [ght_pkg::WORD_W-1:0]  out_hdl,
  output logic [ght_pkg::WORD_W-1:0]  out_payload
);
  import ght_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RAM_W  = GEN_W + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t                   state_r;
  cmd_t                     cmd_r;
  logic [SLOT_W-1:0]        slot_r;
  logic                     found_r;
  logic [NUM_SLOTS-1:0]     occ_r;
  logic [NUM_SLOTS-1:0]     gen_ok_r;
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [WORD_W-1:0]        out_hdl_r;
  logic [WORD_W-1:0]        out_payload_r;

  logic [SLOT_W-1:0]        free_idx;
  logic                     free_any;
  logic [SLOT_W-1:0]        issue_slot;
  logic [SLOT_W-1:0]        raddr;
  logic [RAM_W-1:0]         rdata;
  logic [GEN_W-1:0]         gen_rd;
  logic [PAYLOAD_BITS-1:0]  pay_rd;
  logic [GEN_W-1:0]         gen_cur;
  logic [GEN_W-1:0]         gen_inc;
  logic                     live;
  logic [PAYLOAD_BITS+WORD_W-1:0] pin_ext;
  logic [PAYLOAD_BITS+WORD_W-1:0] pout_ext;
  logic                     out_free;
  logic                     fire;
  logic                     we;
  logic [RAM_W-1:0]         wdata;
  logic                     occ_set;
  logic                     occ_clr;
  status_t                  res_status;
  logic [WORD_W-1:0]        res_handle;
  logic [WORD_W-1:0]        res_payload;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!occ_r[i]) begin
        free_idx = SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign issue_slot = (cmd_r.op == OP_INSERT) ? free_idx : cmd_r.idx[SLOT_W-1:0];
  assign raddr      = (state_r == ST_ISSUE) ? issue_slot : slot_r;

  ght_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (slot_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign gen_rd   = rdata[RAM_W-1:PAYLOAD_BITS];
  assign pay_rd   = rdata[PAYLOAD_BITS-1:0];
  assign gen_cur  = gen_ok_r[slot_r] ? gen_rd : GEN_RESET;
  assign gen_inc  = (gen_cur == GEN_MAX) ? GEN_FIRST : (gen_cur + GEN_W'(1));
  assign live     = cmd_r.ok && occ_r[slot_r] && (gen_cur == cmd_r.gen);
  assign pin_ext  = {{PAYLOAD_BITS{1'b0}}, cmd_r.payload};
  assign pout_ext = {{WORD_W{1'b0}}, pay_rd};

  assign out_free = !out_valid_r || out_tready;
  assign fire     = (state_r == ST_EXEC) && out_free;
  assign pop      = head.valid && ((state_r == ST_IDLE) || fire);

  always_comb begin
    we          = 1'b0;
    wdata       = '0;
    occ_set     = 1'b0;
    occ_clr     = 1'b0;
    res_status  = STATUS_INVALID;
    res_handle  = '0;
    res_payload = '0;
    case (cmd_r.op)
      OP_INSERT: begin
        if (found_r) begin
          we         = fire;
          wdata      = {gen_cur, pin_ext[PAYLOAD_BITS-1:0]};
          occ_set    = fire;
          res_status = STATUS_OK;
          res_handle = {gen_cur, IDX_W'(slot_r) + IDX_W'(1)};
        end else begin
          res_status = STATUS_FULL;
        end
      end
      OP_FIND: begin
        if (live) begin
          res_status  = STATUS_OK;
          res_payload = pout_ext[WORD_W-1:0];
        end else begin
          res_status = STATUS_NOTFOUND;
        end
      end
      OP_REMOVE: begin
        if (live) begin
          we         = fire;
          wdata      = {gen_inc, {PAYLOAD_BITS{1'b0}}};
          occ_clr    = fire;
          res_status = STATUS_OK;
        end
      end
      default: begin
        res_status = STATUS_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head.cmd;
    end
    if (state_r == ST_ISSUE) begin
      slot_r  <= issue_slot;
      found_r <= free_any;
    end
    if (fire) begin
      out_status_r  <= res_status;
      out_hdl_r     <= res_handle;
      out_payload_r <= res_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      gen_ok_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (fire) begin
            state_r <= head.valid ? ST_ISSUE : ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (occ_set) begin
        occ_r[slot_r] <= 1'b1;
      end
      if (occ_clr) begin
        occ_r[slot_r] <= 1'b0;
      end
      if (we) begin
        gen_ok_r[slot_r] <= 1'b1;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_status  = out_status_r;
  assign out_hdl     = out_hdl_r;
  assign out_payload = out_payload_r;

endmodule

@@ src/generational_handle_table.sv @@
// a request passes the queue, the table read and the execute step before its result is valid
// the table logic takes one request at a time: its slot ram read and write back end first
// the input side takes up to two requests ahead of the table logic
// reset (rst_n low, synchronous): every slot free, every generation reads as one
// per-slot written bits stand in for the generation reset, so no clearing pass is run
`timescale 1ns / 1ps
module generational_handle_table #(
  parameter int NUM_SLOTS    = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // opcode, handle_in, payload_in, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // status, handle_out, payload_out, zero pad
);
  import ght_pkg::*;

  q_head_t           head;
  logic              pop;
  status_t           out_status;
  logic [WORD_W-1:0] out_hdl;
  logic [WORD_W-1:0] out_payload;

  ght_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .pop       (pop),
    .head      (head)
  );

  ght_back #(
    .NUM_SLOTS    (NUM_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_status  (out_status),
    .out_hdl     (out_hdl),
    .out_payload (out_payload)
  );

  assign out_tdata = {6'd0, out_payload, out_hdl, out_status};

`ifndef ASSERT_OFF
  a_handle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_hdl != '0) |-> (out_hdl[15:0] != '0) && (out_hdl[31:16] != '0))
    else $error("issued handle has a zero field");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !((out_hdl != '0) && (out_payload != '0)))
    else $error("handle and payload both set");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status != STATUS_OK) |-> (out_hdl == '0) && (out_payload == '0))
    else $error("failed request carries data");

  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> head.valid)
    else $error("accepted request missing from queue");
`endif

endmodule
